// ----- hdl/gtj_pkg.sv -----
package gtj_pkg;

    localparam int WORD_W = 5;
    localparam int LW_W   = 6;
    localparam int SP_W   = 6;
    localparam int SUM_W  = 7;
    localparam int CALC_W = 9;

    localparam logic [LW_W-1:0] LW_RESET = 6'd16;

    typedef struct packed {
        logic [WORD_W-1:0] len;
        logic              pre;    // full flush of the pending line first
        logic              long;   // overlong word, alone on its line
        logic              store;  // append word to pending line
        logic              post;   // full flush after the append
        logic              fin;    // final flush, single spaces
    } cmd_t;

endpackage

// ----- hdl/greedy_text_justifier_top.sv -----
// channel  | dir | tdata                                   | tuser    | tlast
// s_       | in  | [4:0] word_length                       | -        | final_word
// m_       | out | [4:0] out_word_length, [10:5] spaces   | line_end | run_last
// cfg_wr   | in  | cfg_wr_data = line_width, no handshake  | -        | -
//
// A word that starts no line passes the front end and the command queue and is then written to the word store.
// A full line runs the gap divider (spare state, then divide), then reads each word
// from the store and loads it into the output register; the final line skips the divider.
// Reset clears control state; line_width returns to 16. No clearing pass.
// A 2-entry command queue lets the input run on while m_tready is low.
module greedy_text_justifier_top #(
    parameter int MAX_WORDS_PER_LINE = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [4:0] word_length, [7:5] zero
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [4:0] out_word_length, [10:5] spaces_after, [15:11] zero
    output logic        m_tuser,   // [0] line_end
    output logic        m_tlast
);
    import gtj_pkg::*;

    logic [LW_W-1:0]   line_width_reg, line_width_next;
    logic              q_push, q_full, q_pop, q_valid;
    cmd_t              push_cmd, pop_cmd;
    logic [WORD_W-1:0] out_len;
    logic [SP_W-1:0]   out_spaces;

    assign line_width_next = cfg_wr_en ? cfg_wr_data : line_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= LW_RESET;
        end else begin
            line_width_reg <= line_width_next;
        end
    end

    gtj_front #(.MAX_WORDS(MAX_WORDS_PER_LINE)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .line_width (line_width_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_len     (s_tdata[WORD_W-1:0]),
        .in_fin     (s_tlast),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (push_cmd)
    );

    gtj_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_cmd   (pop_cmd)
    );

    gtj_back #(.MAX_WORDS(MAX_WORDS_PER_LINE)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .line_width (line_width_reg),
        .q_valid    (q_valid),
        .q_cmd      (pop_cmd),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_len    (out_len),
        .out_spaces (out_spaces),
        .out_end    (m_tuser),
        .out_last   (m_tlast)
    );

    assign m_tdata = {5'd0, out_spaces, out_len};
endmodule

// ----- hdl/gtj_ram.sv -----
module gtj_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- hdl/gtj_div.sv -----
module gtj_div #(
    parameter int W = 6
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);
    localparam int STEP_W = $clog2(W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [W-1:0]      rem_reg, rem_next;
    logic [W-1:0]      quo_reg, quo_next;
    logic [W-1:0]      dsr_reg, dsr_next;
    logic [W:0]        trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[W-1]};
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(W);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

// ----- hdl/gtj_front.sv -----
module gtj_front #(
    parameter int MAX_WORDS = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [gtj_pkg::LW_W-1:0]  line_width,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [gtj_pkg::WORD_W-1:0] in_len,
    input  logic                      in_fin,
    input  logic                      q_full,
    output logic                      q_push,
    output gtj_pkg::cmd_t             q_cmd
);
    import gtj_pkg::*;

    localparam int CNT_W = $clog2(MAX_WORDS + 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CALC_W-1:0] c1, s1, c2, s2, w_ext;
    logic              flush;
    cmd_t              cmd;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;
    assign w_ext    = CALC_W'(line_width);

    always_comb begin
        cmd       = '0;
        cmd.len   = in_len;
        cnt_next  = cnt_reg;
        sum_next  = sum_reg;
        c1        = CALC_W'(cnt_reg);
        s1        = CALC_W'(sum_reg);
        c2        = c1;
        s2        = s1;
        flush     = 1'b0;
        if (in_len != '0) begin
            if (CALC_W'(in_len) > w_ext) begin
                cmd.pre  = (cnt_reg != '0);
                cmd.long = 1'b1;
                c2       = '0;
                s2       = '0;
            end else begin
                flush = (c1 >= CALC_W'(MAX_WORDS)) ||
                        ((cnt_reg != '0) && (s1 + c1 + CALC_W'(in_len) > w_ext));
                cmd.pre   = flush;
                cmd.store = 1'b1;
                if (flush) begin
                    c1 = '0;
                    s1 = '0;
                end
                c2 = c1 + CALC_W'(1);
                s2 = s1 + CALC_W'(in_len);
                if (s2 + c2 - CALC_W'(1) == w_ext) begin
                    cmd.post = 1'b1;
                    c2       = '0;
                    s2       = '0;
                end
            end
        end
        if (in_fin) begin
            cmd.fin = (c2 != '0);
            c2      = '0;
            s2      = '0;
        end
        if (q_push) begin
            cnt_next = c2[CNT_W-1:0];
            sum_next = s2[SUM_W-1:0];
        end
    end

    assign q_cmd = cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            sum_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            sum_reg <= sum_next;
        end
    end
endmodule

// ----- hdl/gtj_fifo.sv -----
module gtj_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  gtj_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output gtj_pkg::cmd_t pop_cmd
);
    import gtj_pkg::*;

    cmd_t       slot_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] fill_reg, fill_next;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign pop_cmd   = slot_reg[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        fill_next = fill_reg;
        if (push) begin
            wptr_next = !wptr_reg;
        end
        if (pop) begin
            rptr_next = !rptr_reg;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
        if (push) begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end
endmodule

// ----- hdl/gtj_back.sv -----
module gtj_back #(
    parameter int MAX_WORDS = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [gtj_pkg::LW_W-1:0]   line_width,
    input  logic                       q_valid,
    input  gtj_pkg::cmd_t              q_cmd,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [gtj_pkg::WORD_W-1:0] out_len,
    output logic [gtj_pkg::SP_W-1:0]   out_spaces,
    output logic                       out_end,
    output logic                       out_last
);
    import gtj_pkg::*;

    localparam int CNT_W = $clog2(MAX_WORDS + 1);
    localparam int AW    = $clog2(MAX_WORDS);
    localparam int DIV_W = (CNT_W > LW_W) ? CNT_W : LW_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_SPARE = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_WR    = 3'd5;
    localparam logic [2:0] S_LONG  = 3'd6;

    logic [2:0]        state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [DIV_W-1:0]  q_reg, q_next;
    logic [DIV_W-1:0]  r_reg, r_next;
    logic              fin_mode_reg, fin_mode_next;
    logic              ph_last_reg, ph_last_next;
    logic              ov_reg, ov_next;
    logic [WORD_W-1:0] olen_reg, olen_next;
    logic [SP_W-1:0]   osp_reg, osp_next;
    logic              oend_reg, oend_next;
    logic              olast_reg, olast_next;

    logic              ram_we;
    logic [WORD_W-1:0] ram_rdata;
    logic              div_start, div_done;
    logic [DIV_W-1:0]  div_q, div_r;
    logic [DIV_W-1:0]  spare, gaps;
    logic [SUM_W-1:0]  w_ext;
    logic              slot_free, last_word;

    gtj_ram #(.DATA_W(WORD_W), .DEPTH(MAX_WORDS)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (cmd_reg.len),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    gtj_div #(.W(DIV_W)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (spare),
        .divisor   (gaps),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign w_ext     = SUM_W'(line_width);
    assign gaps      = DIV_W'(cnt_reg - CNT_W'(1));
    assign slot_free = !ov_reg || out_ready;
    assign last_word = (CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg;

    always_comb begin
        spare = (w_ext >= sum_reg) ? DIV_W'(w_ext - sum_reg) : '0;
        if (spare < gaps) begin
            spare = gaps;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        idx_next      = idx_reg;
        q_next        = q_reg;
        r_next        = r_reg;
        fin_mode_next = fin_mode_reg;
        ph_last_next  = ph_last_reg;
        ov_next       = ov_reg && !out_ready;
        olen_next     = olen_reg;
        osp_next      = osp_reg;
        oend_next     = oend_reg;
        olast_next    = olast_reg;
        ram_we        = 1'b0;
        div_start     = 1'b0;
        q_pop         = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                idx_next = '0;
                priority if (cmd_reg.pre) begin
                    cmd_next.pre  = 1'b0;
                    fin_mode_next = 1'b0;
                    ph_last_next  = !(cmd_reg.long || cmd_reg.post || cmd_reg.fin);
                    state_next    = S_SPARE;
                end else if (cmd_reg.long) begin
                    cmd_next.long = 1'b0;
                    ph_last_next  = !(cmd_reg.post || cmd_reg.fin);
                    state_next    = S_LONG;
                end else if (cmd_reg.store) begin
                    cmd_next.store = 1'b0;
                    ram_we         = 1'b1;
                    cnt_next       = cnt_reg + CNT_W'(1);
                    sum_next       = sum_reg + SUM_W'(cmd_reg.len);
                end else if (cmd_reg.post) begin
                    cmd_next.post = 1'b0;
                    fin_mode_next = 1'b0;
                    ph_last_next  = !cmd_reg.fin;
                    state_next    = S_SPARE;
                end else if (cmd_reg.fin) begin
                    cmd_next.fin  = 1'b0;
                    fin_mode_next = 1'b1;
                    ph_last_next  = 1'b1;
                    state_next    = S_RD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_SPARE: begin
                if (gaps == '0) begin
                    q_next     = '0;
                    r_next     = '0;
                    state_next = S_RD;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    q_next     = div_q;
                    r_next     = div_r;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = S_WR;
            end
            S_WR: begin
                if (slot_free) begin
                    ov_next    = 1'b1;
                    olen_next  = ram_rdata;
                    oend_next  = last_word;
                    olast_next = last_word && ph_last_reg;
                    priority if (last_word) begin
                        osp_next = '0;
                    end else if (fin_mode_reg) begin
                        osp_next = SP_W'(1);
                    end else if (DIV_W'(idx_reg) < r_reg) begin
                        osp_next = SP_W'(q_reg + DIV_W'(1));
                    end else begin
                        osp_next = SP_W'(q_reg);
                    end
                    if (last_word) begin
                        cnt_next   = '0;
                        sum_next   = '0;
                        state_next = S_DISP;
                    end else begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_RD;
                    end
                end
            end
            S_LONG: begin
                if (slot_free) begin
                    ov_next    = 1'b1;
                    olen_next  = cmd_reg.len;
                    osp_next   = '0;
                    oend_next  = 1'b1;
                    olast_next = ph_last_reg;
                    state_next = S_DISP;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cmd_reg      <= '0;
            cnt_reg      <= '0;
            sum_reg      <= '0;
            idx_reg      <= '0;
            fin_mode_reg <= 1'b0;
            ph_last_reg  <= 1'b0;
            ov_reg       <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cmd_reg      <= cmd_next;
            cnt_reg      <= cnt_next;
            sum_reg      <= sum_next;
            idx_reg      <= idx_next;
            fin_mode_reg <= fin_mode_next;
            ph_last_reg  <= ph_last_next;
            ov_reg       <= ov_next;
        end
        q_reg     <= q_next;
        r_reg     <= r_next;
        olen_reg  <= olen_next;
        osp_reg   <= osp_next;
        oend_reg  <= oend_next;
        olast_reg <= olast_next;
    end

    assign out_valid  = ov_reg;
    assign out_len    = olen_reg;
    assign out_spaces = osp_reg;
    assign out_end    = oend_reg;
    assign out_last   = olast_reg;
endmodule

// ----- tb/greedy_text_justifier_top_tb.sv -----
`timescale 1ns / 100ps

module greedy_text_justifier_top_tb;
    import gtj_pkg::*;

    localparam int LINE_SLOTS   = 32;
    localparam int SETTLE       = 120;
    localparam int STALL_LIMIT  = 3000;
    localparam int SQUEEZE_LEN  = 400;

    typedef struct packed {
        logic [WORD_W-1:0] len;
        logic              fin;
    } text_word_t;

    typedef struct packed {
        logic [WORD_W-1:0] len;
        logic [SP_W-1:0]   spaces;
        logic              line_end;
        logic              run_last;
    } placed_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [5:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    greedy_text_justifier_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // justifier state mirror
    logic [WORD_W-1:0] line_buf [LINE_SLOTS];
    int unsigned       held_sum;
    int unsigned       held_cnt;
    int unsigned       line_w;

    placed_t    beat_out [$];
    placed_t    placed_q [$];
    text_word_t word_q   [$];

    int  words_queued;
    int  words_taken;
    int  placed_seen;
    int  lines_seen;
    int  widths_used;
    int  errors;
    bit  idle_on;
    bit  squeeze_req;
    int  quiet_cycles;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic place(input int unsigned len, input int unsigned sp, input bit le);
        placed_t p;
        p.len      = len[WORD_W-1:0];
        p.spaces   = sp[SP_W-1:0];
        p.line_end = le;
        p.run_last = 1'b0;
        beat_out.push_back(p);
    endtask

    // full line: spare spread ceil-first over the gaps
    task automatic flush_justified();
        int unsigned gaps;
        int unsigned spare;
        int unsigned e;
        if (held_cnt == 0)
            return;
        gaps  = held_cnt - 1;
        spare = (line_w >= held_sum) ? line_w - held_sum : 0;
        if (spare < gaps)
            spare = gaps;
        for (int i = 0; i < held_cnt; i++) begin
            if (i + 1 == held_cnt) begin
                place(line_buf[i], 0, 1'b1);
            end else begin
                e = (spare + gaps - 1) / gaps;
                place(line_buf[i], e, 1'b0);
                spare -= e;
                gaps--;
            end
        end
        held_sum = 0;
        held_cnt = 0;
    endtask

    task automatic flush_ragged();
        for (int i = 0; i < held_cnt; i++)
            place(line_buf[i], (i + 1 == held_cnt) ? 0 : 1, i + 1 == held_cnt);
        held_sum = 0;
        held_cnt = 0;
    endtask

    task automatic justify_word(input text_word_t w);
        beat_out.delete();
        if (w.len != 0) begin
            if (w.len > line_w) begin
                flush_justified();
                place(w.len, 0, 1'b1);
            end else begin
                if (held_cnt >= LINE_SLOTS ||
                    (held_cnt > 0 && held_sum + held_cnt + w.len > line_w))
                    flush_justified();
                line_buf[held_cnt] = w.len;
                held_sum += w.len;
                held_cnt++;
                if (held_sum + held_cnt - 1 == line_w)
                    flush_justified();
            end
        end
        if (w.fin)
            flush_ragged();
        if (beat_out.size() != 0)
            beat_out[$].run_last = 1'b1;
        foreach (beat_out[i])
            placed_q.push_back(beat_out[i]);
    endtask

    // source side
    text_word_t cur_word;
    int         src_gap;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            src_gap  = 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                justify_word(cur_word);
                words_taken++;
            end
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (word_q.size() != 0) begin
                cur_word = word_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {3'b000, cur_word.len};
                s_tlast  <= cur_word.fin;
                src_gap  = pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // sink side
    int      sink_gap;
    int      hold_cnt;
    placed_t got;
    placed_t want;

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("[%0t] ERROR %s", $realtime, msg);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap = 0;
            hold_cnt = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.len      = m_tdata[WORD_W-1:0];
                got.spaces   = m_tdata[WORD_W+SP_W-1:WORD_W];
                got.line_end = m_tuser;
                got.run_last = m_tlast;
                placed_seen++;
                if (got.line_end)
                    lines_seen++;
                if (placed_q.size() == 0) begin
                    flag_error($sformatf("unexpected beat len=%0d sp=%0d end=%b last=%b",
                        got.len, got.spaces, got.line_end, got.run_last));
                end else begin
                    want = placed_q.pop_front();
                    if (got !== want)
                        flag_error($sformatf(
                            "exp len=%0d sp=%0d end=%b last=%b, got len=%0d sp=%0d end=%b last=%b",
                            want.len, want.spaces, want.line_end, want.run_last,
                            got.len, got.spaces, got.line_end, got.run_last));
                end
            end
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                hold_cnt    = SQUEEZE_LEN;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                sink_gap = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send(input int len, input bit fin);
        text_word_t w;
        w.len = len[WORD_W-1:0];
        w.fin = fin;
        word_q.push_back(w);
        words_queued++;
    endtask

    task automatic drain();
        while (words_taken != words_queued || placed_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_width(input int w);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w[5:0];
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        line_w = w;
        widths_used++;
    endtask

    // mostly words that fit, some overlong, rare early final
    task automatic send_text(input int n, input int w, input bit unit_words);
        int cap;
        int r;
        int len;
        cap = (w < 31) ? w : 31;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (unit_words && r < 85)
                len = 1;
            else if (r < 8)
                len = (w < 31) ? $urandom_range(w + 1, 31) : $urandom_range(1, 31);
            else if (r < 20)
                len = $urandom_range(1, 31);
            else
                len = $urandom_range(1, cap);
            send(len, (i == n - 1 && $urandom_range(0, 2) != 0) ||
                      $urandom_range(0, 99) < 4);
        end
    endtask

    initial begin
        aclk        = 1'b0;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        idle_on     = 1'b1;
        squeeze_req = 1'b0;
        held_sum    = 0;
        held_cnt    = 0;
        line_w      = LW_RESET;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // exact fill, overlong alone and after a pending line, zero-length words
        set_width(16);
        send(5, 0);  send(5, 0);  send(4, 0);
        send(31, 0);
        send(3, 0);  send(7, 0);  send(31, 0);
        send(1, 0);  send(0, 0);  send(2, 1);
        send(0, 1);
        send(10, 0); send(0, 1);
        send(9, 0);  send(8, 0);  send(16, 0);
        drain();

        // widest line, leave a line pending for the shrink below
        set_width(63);
        send(31, 0); send(31, 0);
        send(20, 0); send(20, 0); send(20, 0);
        drain();

        // shrunk width: spare below gap count, then min width
        set_width(1);
        send(1, 0);  send(1, 1);  send(2, 1);
        drain();

        // output held off long while input keeps offering
        set_width(20);
        idle_on     = 1'b0;
        squeeze_req = 1'b1;
        send_text(16, 20, 1'b0);
        drain();
        idle_on = 1'b1;

        set_width(63);
        send_text(14, 63, 1'b0);
        drain();

        set_width(1);
        send_text(12, 1, 1'b0);
        drain();

        set_width(63);
        send_text(16, 63, 1'b1);
        drain();

        idle_on = 1'b0;
        set_width(7);
        send_text(14, 7, 1'b0);
        drain();
        idle_on = 1'b1;

        for (int k = 0; k < 3; k++) begin
            automatic int w = $urandom_range(2, 62);
            set_width(w);
            send_text(5, w, 1'b0);
            drain();
        end

        $display("Fed %0d words over %0d width settings (1 to 63, incl. shrink mid-line);",
                 words_taken, widths_used);
        $display("checked %0d placed words closing %0d lines, %0d mismatches.",
                 placed_seen, lines_seen, errors);
        if (errors == 0 && placed_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
